// ----- design/slids_pkg.sv -----
package slids_pkg;

   localparam int CAPACITY_DEF = 16;

   localparam int TYPE_W  = 2;
   localparam int VALUE_W = 32;
   localparam int STAT_W  = 2;
   localparam int INDEX_W = 4;
   localparam int COUNT_W = 5;

   // request codes
   localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_DELETE = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_SEARCH = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

   typedef struct packed {
      logic capture;   // latch request word
      logic compare;   // register per-cell compare vectors
      logic apply;     // load result word
      logic write;     // shift cells and update count
   } slids_cmd_type;

   typedef struct packed {
      logic is_insert;
      logic is_delete;
      logic full;
      logic hit;
   } slids_stat_type;

endpackage

// ----- design/slids_req_if.sv -----
interface slids_req_if;
   logic                                   valid;
   logic                                   ready;
   logic        [slids_pkg::TYPE_W-1:0]    req_type;
   logic signed [slids_pkg::VALUE_W-1:0]   value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink   (input valid, input req_type, input value, output ready);
endinterface

// ----- design/slids_rsp_if.sv -----
interface slids_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [slids_pkg::STAT_W-1:0]     status;
   logic [slids_pkg::INDEX_W-1:0]    found_index;
   logic [slids_pkg::COUNT_W-1:0]    entry_count;

   modport source (output valid, output status, output found_index, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input found_index, input entry_count,
                   output ready);
endinterface

// ----- design/slids_ctrl.sv -----
module slids_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  slids_pkg::slids_stat_type stat,
   output slids_pkg::slids_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_CMP   = 3'b010,
      S_APPLY = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_CMP;
            end
         end
         S_CMP: begin
            cmd.compare = 1'b1;
            state_in    = S_APPLY;
         end
         S_APPLY: begin
            // wait for the result register to drain
            if (out_free) begin
               cmd.apply    = 1'b1;
               cmd.write    = (stat.is_insert && !stat.full) ||
                              (stat.is_delete && stat.hit);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- design/slids_dp.sv -----
module slids_dp #(
   parameter int CAPACITY = slids_pkg::CAPACITY_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic        [slids_pkg::TYPE_W-1:0]  req_type,
   input  logic signed [slids_pkg::VALUE_W-1:0] req_value,
   input  slids_pkg::slids_cmd_type             cmd,
   output slids_pkg::slids_stat_type            stat,
   output logic        [slids_pkg::STAT_W-1:0]  rsp_status,
   output logic        [slids_pkg::INDEX_W-1:0] rsp_found_index,
   output logic        [slids_pkg::COUNT_W-1:0] rsp_entry_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);

   logic        [slids_pkg::TYPE_W-1:0]  type_ff;
   logic signed [slids_pkg::VALUE_W-1:0] value_ff;
   logic signed [slids_pkg::VALUE_W-1:0] entry_ff [CAPACITY];
   logic signed [slids_pkg::VALUE_W-1:0] entry_in [CAPACITY];
   logic        [CNT_W-1:0]              count_ff, count_in;
   logic        [CAPACITY-1:0]           lt_ff, le_ff, eq_ff;
   logic        [CAPACITY-1:0]           lt_in, le_in, eq_in;
   logic        [CAPACITY-1:0]           first_hot;
   logic        [IDX_W-1:0]              hit_idx;
   logic        [slids_pkg::STAT_W-1:0]  status_ff, status_in;
   logic        [slids_pkg::INDEX_W-1:0] index_ff;
   logic        [slids_pkg::COUNT_W-1:0] ecount_ff;
   logic        [IDX_W+slids_pkg::INDEX_W-1:0] idx_wide;
   logic        [CNT_W+slids_pkg::COUNT_W-1:0] cnt_wide;
   logic                                 is_search, empty;

   // per-cell compare against the latched request value
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         logic valid_c;
         valid_c  = (CNT_W'(i) < count_ff);
         lt_in[i] = valid_c && (entry_ff[i] <  value_ff);
         le_in[i] = valid_c && (entry_ff[i] <= value_ff);
         eq_in[i] = valid_c && (entry_ff[i] == value_ff);
      end
   end

   // lt is a prefix; first_hot marks the boundary cell
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (i == 0) first_hot[i] = !lt_ff[i];
         else        first_hot[i] = !lt_ff[i] && lt_ff[i-1];
         if (first_hot[i]) hit_idx = hit_idx | IDX_W'(i);
      end
   end

   assign stat.is_insert = (type_ff == slids_pkg::REQ_INSERT);
   assign stat.is_delete = (type_ff == slids_pkg::REQ_DELETE);
   assign stat.full      = (count_ff == CNT_W'(CAPACITY));
   assign stat.hit       = |eq_ff;
   assign is_search      = (type_ff == slids_pkg::REQ_SEARCH);
   assign empty          = (count_ff == '0);

   // cell shift network: insert opens a slot, delete closes one
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         entry_in[i] = entry_ff[i];
         if (stat.is_insert) begin
            if (!le_ff[i]) begin
               if (i == 0)           entry_in[i] = value_ff;
               else if (le_ff[i-1])  entry_in[i] = value_ff;
               else                  entry_in[i] = entry_ff[i-1];
            end
         end else begin
            if (!lt_ff[i] && (i < CAPACITY - 1)) entry_in[i] = entry_ff[i+1];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.write) begin
         if (stat.is_insert) count_in = count_ff + CNT_W'(1);
         else                count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      priority if (stat.is_insert) status_in = stat.full ? slids_pkg::ST_FULL : slids_pkg::ST_OK;
      else if (stat.is_delete) begin
         if (empty)          status_in = slids_pkg::ST_EMPTY;
         else if (stat.hit)  status_in = slids_pkg::ST_OK;
         else                status_in = slids_pkg::ST_NOT_FOUND;
      end else if (is_search) begin
         status_in = stat.hit ? slids_pkg::ST_OK : slids_pkg::ST_NOT_FOUND;
      end else               status_in = slids_pkg::ST_OK;
   end

   assign idx_wide = ((stat.is_delete || is_search) && stat.hit) ?
                     (IDX_W+slids_pkg::INDEX_W)'(hit_idx) : '0;
   assign cnt_wide = (CNT_W+slids_pkg::COUNT_W)'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff  <= req_type;
         value_ff <= req_value;
      end
      if (cmd.compare) begin
         lt_ff <= lt_in;
         le_ff <= le_in;
         eq_ff <= eq_in;
      end
      if (cmd.write) begin
         for (int i = 0; i < CAPACITY; i++) entry_ff[i] <= entry_in[i];
      end
      if (cmd.apply) begin
         status_ff <= status_in;
         index_ff  <= idx_wide[slids_pkg::INDEX_W-1:0];
         ecount_ff <= cnt_wide[slids_pkg::COUNT_W-1:0];
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_found_index = index_ff;
   assign rsp_entry_count = ecount_ff;

endmodule

// ----- design/sorted_list_insert_delete_search.sv -----
// Channel   Port       Dir  Word
// --------  ---------  ---  -------------------------------------------
// request   req_chan   in   req_type (insert/delete/search), value
// response  rsp_chan   out  status, found_index, entry_count
//
// Each word passes through latch, parallel compare in every cell, then
// shift/update and load of the response register; one request is in
// flight at a time.
// Reset clears the count, sequencer state and response valid; cell contents stay undefined until written.
// A stalled response holds the block in its update step; the next request
// may still be taken while the last response waits.
module sorted_list_insert_delete_search #(
   parameter int CAPACITY = slids_pkg::CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   slids_req_if.sink   req_chan,
   slids_rsp_if.source rsp_chan
);

   slids_pkg::slids_cmd_type  cmd;   // controller -> datapath
   slids_pkg::slids_stat_type stat;  // datapath -> controller

   // sequencer: latch / compare / apply, owns both handshakes
   slids_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // row of sorted cells, count, result register
   slids_dp #(.CAPACITY(CAPACITY)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_type        (req_chan.req_type),
      .req_value       (req_chan.value),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_status      (rsp_chan.status),
      .rsp_found_index (rsp_chan.found_index),
      .rsp_entry_count (rsp_chan.entry_count)
   );

endmodule

// ----- design/slids_checker.sv -----
module slids_checker #(
   parameter int CAPACITY = slids_pkg::CAPACITY_DEF
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [slids_pkg::STAT_W-1:0]    status,
   input logic [slids_pkg::INDEX_W-1:0]   found_index,
   input logic [slids_pkg::COUNT_W-1:0]   entry_count
);

   localparam logic [31:0] CAP_BITS = 32'(CAPACITY);

   // a pending response is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // one request at a time
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another in flight");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status == slids_pkg::ST_FULL) |->
      (entry_count == CAP_BITS[slids_pkg::COUNT_W-1:0]))
      else $error("full status with wrong count");

   a_index_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (found_index != '0) |-> (status == slids_pkg::ST_OK))
      else $error("index reported on failed request");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status == slids_pkg::ST_EMPTY) |-> (entry_count == '0))
      else $error("empty status with nonzero count");

endmodule

bind sorted_list_insert_delete_search slids_checker #(.CAPACITY(CAPACITY)) u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .status      (rsp_chan.status),
   .found_index (rsp_chan.found_index),
   .entry_count (rsp_chan.entry_count)
);

// ----- tb/sorted_list_insert_delete_search_test.sv -----
module sorted_list_insert_delete_search_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_DEPTH = slids_pkg::CAPACITY_DEF;
   // code 3 is not decoded by the block: list untouched, status ok
   localparam logic [slids_pkg::TYPE_W-1:0] REQ_UNUSED = 2'd3;
   // cycles with no word moving on either channel before we give up
   localparam int STALL_LIMIT = 1000;
   // leave a margin at the end
   localparam int TAIL_CYCLES = 12;

   typedef struct packed {
      logic [slids_pkg::STAT_W-1:0]  status;
      logic [slids_pkg::INDEX_W-1:0] found_index;
      logic [slids_pkg::COUNT_W-1:0] entry_count;
   } list_rsp_type;

   logic clock = 1'b0;
   logic reset;

   slids_req_if req_chan ();
   slids_rsp_if rsp_chan ();

   sorted_list_insert_delete_search dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow of the list contents; only slots below list_len are meaningful.
   logic signed [slids_pkg::VALUE_W-1:0] list_vals [LIST_DEPTH];
   int unsigned                          list_len;

   list_rsp_type pending_rsp [$];   // responses still owed by the block
   int           error_count;
   int           send_idle_pct;     // chance per cycle that the sender holds off
   int           recv_idle_pct;     // chance per cycle that rsp ready is low
   int           quiet_cycles;

   // Position of the first slot equal to v, or -1 if none.
   function automatic int first_slot(input logic signed [slids_pkg::VALUE_W-1:0] v);
      for (int i = 0; i < int'(list_len); i++)
         if (list_vals[i] == v)
            return i;
      return -1;
   endfunction

   // Apply one request to the shadow list and return the response it owes.
   function automatic list_rsp_type apply_request(
      input logic        [slids_pkg::TYPE_W-1:0]  kind,
      input logic signed [slids_pkg::VALUE_W-1:0] v);
      list_rsp_type rsp;
      int unsigned  pos;
      int           hit;
      rsp.status      = slids_pkg::ST_OK;
      rsp.found_index = '0;
      case (kind)
         slids_pkg::REQ_INSERT: begin
            if (list_len >= LIST_DEPTH) begin
               rsp.status = slids_pkg::ST_FULL;
            end else begin
               // new value lands after any equal values
               pos = 0;
               while (pos < list_len && list_vals[pos] <= v)
                  pos++;
               for (int i = int'(list_len); i > int'(pos); i--)
                  list_vals[i] = list_vals[i-1];
               list_vals[pos] = v;
               list_len++;
            end
         end
         slids_pkg::REQ_DELETE: begin
            if (list_len == 0) begin
               rsp.status = slids_pkg::ST_EMPTY;
            end else begin
               hit = first_slot(v);
               if (hit < 0) begin
                  rsp.status = slids_pkg::ST_NOT_FOUND;
               end else begin
                  for (int i = hit; i + 1 < int'(list_len); i++)
                     list_vals[i] = list_vals[i+1];
                  list_len--;
                  rsp.found_index = slids_pkg::INDEX_W'(hit);
               end
            end
         end
         slids_pkg::REQ_SEARCH: begin
            // an empty list is simply a miss here
            hit = first_slot(v);
            if (hit < 0)
               rsp.status = slids_pkg::ST_NOT_FOUND;
            else
               rsp.found_index = slids_pkg::INDEX_W'(hit);
         end
         default: ;
      endcase
      rsp.entry_count = slids_pkg::COUNT_W'(list_len);
      return rsp;
   endfunction

   // Offer one request word; returns at the edge where it is taken.
   // valid is left high so a following word can go out back to back.
   task automatic send_word(input logic        [slids_pkg::TYPE_W-1:0]  kind,
                            input logic signed [slids_pkg::VALUE_W-1:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= kind;
      req_chan.value    <= v;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      pending_rsp.push_back(apply_request(kind, v));
   endtask

   // Drop valid and wait until every owed response has come back.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (pending_rsp.size() != 0)
         @(posedge clock);
   endtask

   // Mostly values that hit the list or sit close together, some anywhere.
   function automatic logic signed [slids_pkg::VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (list_len != 0 && r < 45)
         return list_vals[$urandom_range(list_len - 1)];
      if (r < 75)
         return int'($urandom_range(16)) - 8;
      return $urandom;
   endfunction

   // Requests against an empty list: delete reports empty, search misses, code 3 is ignored.
   task automatic test_empty_list();
      send_word(slids_pkg::REQ_DELETE, 32'sd0);
      send_word(slids_pkg::REQ_SEARCH, 32'sd7);
      send_word(REQ_UNUSED, -32'sd1);
   endtask

   // Fill to capacity with the value extremes and duplicates, then overflow.
   task automatic test_fill_to_capacity();
      logic signed [slids_pkg::VALUE_W-1:0] seeds [LIST_DEPTH];
      seeds = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sd1, 32'sd5,
                32'sd5, 32'sd5, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sd100, -32'sd100,
                32'sh7FFF_FFFE, 32'sh8000_0001, 32'sd0, 32'sd2};
      foreach (seeds[i])
         send_word(slids_pkg::REQ_INSERT, seeds[i]);
      send_word(slids_pkg::REQ_INSERT, 32'sd3);                // full: dropped
   endtask

   // Hits at both ends, a miss, duplicate removal, a missing delete and code 3.
   task automatic test_lookup_and_remove();
      send_word(slids_pkg::REQ_SEARCH, 32'sh8000_0000);        // first slot
      send_word(slids_pkg::REQ_SEARCH, 32'sh7FFF_FFFF);        // last slot
      send_word(slids_pkg::REQ_SEARCH, 32'sd3);                // miss
      send_word(slids_pkg::REQ_DELETE, 32'sd5);                // first of three equal
      send_word(slids_pkg::REQ_DELETE, 32'sd4);                // not there
      send_word(REQ_UNUSED, 32'sd5);
   endtask

   // Bursts that lean toward growing or shrinking the list, so the count
   // sweeps between empty and full many times with random content.
   task automatic test_random_traffic(input int n_words);
      int                             r;
      int                             ins_pct;
      int                             del_pct;
      bit                             grow;
      logic [slids_pkg::TYPE_W-1:0]   kind;
      grow = 1'b1;
      for (int n = 0; n < n_words; n++) begin
         if (n % 25 == 0)
            grow = (list_len < LIST_DEPTH / 2) ? 1'b1 : ($urandom_range(3) == 0);
         ins_pct = grow ? 65 : 25;
         del_pct = grow ? 15 : 50;
         r = $urandom_range(99);
         if (r < 4)
            kind = REQ_UNUSED;
         else if (r < 4 + ins_pct)
            kind = slids_pkg::REQ_INSERT;
         else if (r < 4 + ins_pct + del_pct)
            kind = slids_pkg::REQ_DELETE;
         else
            kind = slids_pkg::REQ_SEARCH;
         send_word(kind, pick_value());
      end
   endtask

   // Response side: check each taken word, then pick ready for next cycle.
   always @(posedge clock) begin
      list_rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_rsp.size() == 0) begin
            $error("response word with nothing outstanding: status %0d index %0d count %0d",
                   rsp_chan.status, rsp_chan.found_index, rsp_chan.entry_count);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_chan.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_chan.status);
               error_count++;
            end
            if (rsp_chan.found_index !== want.found_index) begin
               $error("found_index: expected %0d, actual %0d",
                      want.found_index, rsp_chan.found_index);
               error_count++;
            end
            if (rsp_chan.entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, actual %0d",
                      want.entry_count, rsp_chan.entry_count);
               error_count++;
            end
         end
      end
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog: trips when neither channel moves a word for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.req_type = slids_pkg::REQ_INSERT;
      req_chan.value    = '0;
      list_len          = 0;
      error_count       = 0;
      send_idle_pct     = 8;
      recv_idle_pct     = 50;
      foreach (list_vals[i])
         list_vals[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_list();
      test_fill_to_capacity();
      test_lookup_and_remove();

      // sender mostly busy, receiver stalls often
      test_random_traffic(275);
      // then the reverse
      send_idle_pct = 50;
      recv_idle_pct = 8;
      test_random_traffic(275);
      // full rate both ways
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(275);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
